// File: design/hbs_pkg.sv
// shared constants for the heightmap bilinear sampler
`timescale 1ns / 1ps
package hbs_pkg;
   localparam int GRID_MAX    = 256;
   localparam int STORE_DEPTH = (GRID_MAX + 1) * (GRID_MAX + 1);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CELL_W      = $clog2(GRID_MAX + 1);

   localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Z     = 3'd1;
   localparam logic [2:0] REG_BASE_HEIGHT  = 3'd2;
   localparam logic [2:0] REG_INV_EXTENT   = 3'd3;
   localparam logic [2:0] REG_SAMPLE_DELTA = 3'd4;
   localparam logic [2:0] REG_GRID_CELLS   = 3'd5;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;
endpackage

// File: design/heightmap_bilinear_sampler_unit.sv
// heightmap store with bilinear height and surface normal query
`timescale 1ns / 1ps
// A write item stores one Q8.8 sample and is taken while the block is idle. A query
// item runs until its result is loaded and the block takes no new item meanwhile: five
// bilinear samples each locate the cell on the shared multiplier for both axes, form
// the row address, make four heightmap reads through the single memory read port and
// take three interpolation multiplies; the normal then needs a setup step, a normalizing
// shift of one bit per cycle until the largest component tops out at bit 23, three
// squares, a square root, three divisions and a final step that loads the result once
// the output register is free. A finished result waits in the output register while
// write items keep being accepted.
module heightmap_bilinear_sampler_unit import hbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [16:0]        req_entry_index,
   input  logic signed [15:0] req_entry_height,
   input  logic signed [31:0] req_world_x,
   input  logic signed [31:0] req_world_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_height,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic signed [15:0] rsp_normal_z
);
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_AX   = 5'd1;
   localparam logic [4:0] S_ML   = 5'd2;
   localparam logic [4:0] S_MH   = 5'd3;
   localparam logic [4:0] S_MG   = 5'd4;
   localparam logic [4:0] S_ROW  = 5'd5;
   localparam logic [4:0] S_RD0  = 5'd6;
   localparam logic [4:0] S_RD1  = 5'd7;
   localparam logic [4:0] S_RD2  = 5'd8;
   localparam logic [4:0] S_RD3  = 5'd9;
   localparam logic [4:0] S_RD4  = 5'd10;
   localparam logic [4:0] S_IA   = 5'd11;
   localparam logic [4:0] S_IB   = 5'd12;
   localparam logic [4:0] S_IT   = 5'd13;
   localparam logic [4:0] S_N0   = 5'd14;
   localparam logic [4:0] S_NORM = 5'd15;
   localparam logic [4:0] S_SQ   = 5'd16;
   localparam logic [4:0] S_SQRT = 5'd17;
   localparam logic [4:0] S_DIVI = 5'd18;
   localparam logic [4:0] S_DIV  = 5'd19;
   localparam logic [4:0] S_DONE = 5'd20;

   // configuration
   logic [31:0] origin_x_ff, origin_z_ff, base_height_ff, inv_extent_ff;
   logic [30:0] sample_delta_ff;
   logic [8:0]  grid_cells_ff;

   // control
   logic [4:0] state_ff, state_in;
   logic       axis_ff, axis_in;
   logic [2:0] si_ff, si_in;
   logic [1:0] cidx_ff, cidx_in;
   logic [3:0] it_ff, it_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [31:0]       wx_ff, wx_in, wz_ff, wz_in;
   logic [32:0]       dxp_ff, dxp_in;
   logic [48:0]       plo_ff, plo_in;
   logic [24:0]       u24_ff, u24_in;
   logic [CELL_W-1:0] x0_ff, x0_in, z0_ff, z0_in;
   logic [15:0]       fx_ff, fx_in, fz_ff, fz_in;
   logic [ADDR_W-1:0] row0_ff, row0_in, row1_ff, row1_in;
   logic [15:0]       rdata_ff;
   logic [15:0]       h00_ff, h00_in, h10_ff, h10_in, h01_ff, h01_in, h11_ff, h11_in;
   logic [33:0]       a_ff, a_in, b_ff, b_in;
   logic [27:0]       s0_ff, s0_in;
   logic [28:0]       hx_ff, hx_in, hz_ff, hz_in;
   logic [32:0]       nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic              negx_ff, negx_in, negz_ff, negz_in;
   logic [49:0]       acc_ff, acc_in;
   logic [50:0]       v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [39:0]       rem_ff, rem_in;
   logic [15:0]       q_ff, q_in;
   logic [15:0]       ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic [31:0]       rh_ff, rh_in;
   logic [15:0]       rnx_ff, rnx_in, rny_ff, rny_in, rnz_ff, rnz_in;

   logic signed [15:0] mem [0:STORE_DEPTH-1];

   // combinational helpers
   logic              accept, wr_en;
   logic [CELL_W-1:0] n_eff, x1;
   logic [30:0]       d_eff;
   logic [33:0]       coord, dext;
   logic [31:0]       org;
   logic [34:0]       dx;
   logic signed [34:0] mul_a;
   logic signed [25:0] mul_b;
   logic signed [60:0] prod;
   logic [65:0]       psum;
   logic [ADDR_W-1:0] rd_addr, row0_calc, stride;
   logic [16:0]       dlo, dhi;
   logic [34:0]       dba;
   logic [51:0]       t;
   logic [27:0]       samp;
   logic [23:0]       sel_c;
   logic [28:0]       absx, absz;
   logic [50:0]       rb;
   logic [25:0]       rr;
   logic [41:0]       dsh;
   logic              qbit;
   logic [15:0]       qnext, qcap, qsgn;
   logic [32:0]       hsum;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign wr_en     = accept && (req_operation == OP_WRITE)
                      && (req_entry_index < 17'(STORE_DEPTH));

   assign n_eff = (grid_cells_ff < 9'd2) ? CELL_W'(2) :
                  (grid_cells_ff > 9'(GRID_MAX)) ? CELL_W'(GRID_MAX) :
                  CELL_W'(grid_cells_ff);
   assign d_eff  = (sample_delta_ff == 31'd0) ? 31'd1 : sample_delta_ff;
   assign dext   = {3'b000, d_eff};
   assign stride = ADDR_W'(n_eff) + ADDR_W'(1);
   assign x1     = (x0_ff < n_eff) ? x0_ff + CELL_W'(1) : n_eff;

   // sample point for the current axis
   always_comb begin
      if (!axis_ff) begin
         coord = {{2{wx_ff[31]}}, wx_ff};
         if (si_ff == 3'd1) coord = coord + dext;
         else if (si_ff == 3'd2) coord = coord - dext;
         org = origin_x_ff;
      end else begin
         coord = {{2{wz_ff[31]}}, wz_ff};
         if (si_ff == 3'd3) coord = coord + dext;
         else if (si_ff == 3'd4) coord = coord - dext;
         org = origin_z_ff;
      end
      dx = {coord[33], coord} - {{3{org[31]}}, org};
   end

   always_comb begin
      case (cidx_ff)
         2'd0:    sel_c = nx_ff[23:0];
         2'd1:    sel_c = ny_ff[23:0];
         default: sel_c = nz_ff[23:0];
      endcase
   end

   assign dlo = {h10_ff[15], h10_ff} - {h00_ff[15], h00_ff};
   assign dhi = {h11_ff[15], h11_ff} - {h01_ff[15], h01_ff};
   assign dba = {b_ff[33], b_ff} - {a_ff[33], a_ff};

   // shared multiplier
   always_comb begin
      case (state_ff)
         S_ML: begin
            mul_a = {3'b000, inv_extent_ff};
            mul_b = {9'd0, dxp_ff[16:0]};
         end
         S_MH: begin
            mul_a = {3'b000, inv_extent_ff};
            mul_b = {10'd0, dxp_ff[32:17]};
         end
         S_MG: begin
            mul_a = {10'd0, u24_ff};
            mul_b = {{(26-CELL_W){1'b0}}, n_eff};
         end
         S_ROW: begin
            mul_a = {{(35-CELL_W){1'b0}}, z0_ff};
            mul_b = {{(26-CELL_W){1'b0}}, n_eff};
         end
         S_IA: begin
            mul_a = {{18{dlo[16]}}, dlo};
            mul_b = {10'd0, fx_ff};
         end
         S_IB: begin
            mul_a = {{18{dhi[16]}}, dhi};
            mul_b = {10'd0, fx_ff};
         end
         S_IT: begin
            mul_a = dba;
            mul_b = {10'd0, fz_ff};
         end
         S_SQ: begin
            mul_a = {11'd0, sel_c};
            mul_b = {2'b00, sel_c};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   assign psum      = {17'd0, plo_ff} + {1'b0, prod[47:0], 17'd0};
   assign row0_calc = prod[ADDR_W-1:0] + ADDR_W'(z0_ff);
   assign t         = {{2{a_ff[33]}}, a_ff, 16'd0} + prod[51:0];
   assign samp      = 28'((t + 52'd8388608) >> 24);
   assign absx      = hx_ff[28] ? (29'd0 - hx_ff) : hx_ff;
   assign absz      = hz_ff[28] ? (29'd0 - hz_ff) : hz_ff;
   assign rb        = r_ff + bit_ff;
   assign rr        = (r_ff[25:0] == 26'd0) ? 26'd1 : r_ff[25:0];
   assign dsh       = {15'd0, rr, 1'b0} << it_ff;
   assign qbit      = ({2'b00, rem_ff} >= dsh);
   assign qnext     = {q_ff[14:0], qbit};
   assign qcap      = (qnext > 16'd16384) ? 16'd16384 : qnext;
   assign hsum      = {{5{s0_ff[27]}}, s0_ff} + {base_height_ff[31], base_height_ff};

   always_comb begin
      case (state_ff)
         S_RD1:   rd_addr = row0_ff + ADDR_W'(x1);
         S_RD2:   rd_addr = row1_ff + ADDR_W'(x0_ff);
         S_RD3:   rd_addr = row1_ff + ADDR_W'(x1);
         default: rd_addr = row0_ff + ADDR_W'(x0_ff);
      endcase
   end

   always_comb begin
      if (cidx_ff == 2'd0) qsgn = negx_ff ? (16'd0 - qcap) : qcap;
      else if (cidx_ff == 2'd2) qsgn = negz_ff ? (16'd0 - qcap) : qcap;
      else qsgn = qcap;
   end

   // sequencer
   always_comb begin
      state_in = state_ff; axis_in = axis_ff; si_in = si_ff; cidx_in = cidx_ff;
      it_in = it_ff; rsp_valid_in = rsp_valid_ff;
      wx_in = wx_ff; wz_in = wz_ff; dxp_in = dxp_ff; plo_in = plo_ff; u24_in = u24_ff;
      x0_in = x0_ff; z0_in = z0_ff; fx_in = fx_ff; fz_in = fz_ff;
      row0_in = row0_ff; row1_in = row1_ff;
      h00_in = h00_ff; h10_in = h10_ff; h01_in = h01_ff; h11_in = h11_ff;
      a_in = a_ff; b_in = b_ff; s0_in = s0_ff; hx_in = hx_ff; hz_in = hz_ff;
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff; negx_in = negx_ff; negz_in = negz_ff;
      acc_in = acc_ff; v_in = v_ff; r_in = r_ff; bit_in = bit_ff;
      rem_in = rem_ff; q_in = q_ff; ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff;
      rh_in = rh_ff; rnx_in = rnx_ff; rny_in = rny_ff; rnz_in = rnz_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept && req_operation == OP_QUERY) begin
               wx_in = req_world_x;
               wz_in = req_world_z;
               si_in = 3'd0;
               axis_in = 1'b0;
               state_in = S_AX;
            end
         end
         S_AX: begin
            dxp_in = (!dx[34] && dx != 35'd0) ? dx[32:0] : 33'd0;
            state_in = S_ML;
         end
         S_ML: begin
            plo_in = prod[48:0];
            state_in = S_MH;
         end
         S_MH: begin
            u24_in = (psum[65:40] != 26'd0) ? 25'h1000000 : {1'b0, psum[39:16]};
            state_in = S_MG;
         end
         S_MG: begin
            if (!axis_ff) begin
               x0_in = prod[24 +: CELL_W];
               fx_in = prod[23:8];
               axis_in = 1'b1;
               state_in = S_AX;
            end else begin
               z0_in = prod[24 +: CELL_W];
               fz_in = prod[23:8];
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            row0_in = row0_calc;
            row1_in = (z0_ff < n_eff) ? row0_calc + stride : row0_calc;
            state_in = S_RD0;
         end
         S_RD0: state_in = S_RD1;
         S_RD1: begin
            h00_in = rdata_ff;
            state_in = S_RD2;
         end
         S_RD2: begin
            h10_in = rdata_ff;
            state_in = S_RD3;
         end
         S_RD3: begin
            h01_in = rdata_ff;
            state_in = S_RD4;
         end
         S_RD4: begin
            h11_in = rdata_ff;
            state_in = S_IA;
         end
         S_IA: begin
            a_in = {{2{h00_ff[15]}}, h00_ff, 16'd0} + prod[33:0];
            state_in = S_IB;
         end
         S_IB: begin
            b_in = {{2{h01_ff[15]}}, h01_ff, 16'd0} + prod[33:0];
            state_in = S_IT;
         end
         S_IT: begin
            case (si_ff)
               3'd0:    s0_in = samp;
               3'd1:    hx_in = {samp[27], samp};
               3'd2:    hx_in = hx_ff - {samp[27], samp};
               3'd3:    hz_in = {samp[27], samp};
               default: hz_in = hz_ff - {samp[27], samp};
            endcase
            axis_in = 1'b0;
            if (si_ff == 3'd4) begin
               state_in = S_N0;
            end else begin
               si_in = si_ff + 3'd1;
               state_in = S_AX;
            end
         end
         S_N0: begin
            nx_in = {4'd0, absx};
            ny_in = {1'b0, d_eff, 1'b0};
            nz_in = {4'd0, absz};
            negx_in = !hx_ff[28] && (hx_ff != 29'd0);
            negz_in = !hz_ff[28] && (hz_ff != 29'd0);
            state_in = S_NORM;
         end
         S_NORM: begin
            if ((nx_ff[32:24] | ny_ff[32:24] | nz_ff[32:24]) != 9'd0) begin
               nx_in = nx_ff >> 1;
               ny_in = ny_ff >> 1;
               nz_in = nz_ff >> 1;
            end else if ((nx_ff[32:23] | ny_ff[32:23] | nz_ff[32:23]) == 10'd0) begin
               nx_in = nx_ff << 1;
               ny_in = ny_ff << 1;
               nz_in = nz_ff << 1;
            end else begin
               cidx_in = 2'd0;
               acc_in = 50'd0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            acc_in = acc_ff + {2'b00, prod[47:0]};
            if (cidx_ff == 2'd2) begin
               v_in = {1'b0, acc_ff + {2'b00, prod[47:0]}};
               r_in = 51'd0;
               bit_in = 51'd1 << 50;
               state_in = S_SQRT;
            end else begin
               cidx_in = cidx_ff + 2'd1;
            end
         end
         S_SQRT: begin
            if (v_ff >= rb) begin
               v_in = v_ff - rb;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               cidx_in = 2'd0;
               state_in = S_DIVI;
            end
         end
         S_DIVI: begin
            rem_in = {1'b0, sel_c, 15'd0} + {14'd0, rr};
            q_in = 16'd0;
            it_in = 4'd15;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (qbit) rem_in = rem_ff - dsh[39:0];
            q_in = qnext;
            it_in = it_ff - 4'd1;
            if (it_ff == 4'd0) begin
               case (cidx_ff)
                  2'd0:    ox_in = qsgn;
                  2'd1:    oy_in = qsgn;
                  default: oz_in = qsgn;
               endcase
               if (cidx_ff == 2'd2) begin
                  state_in = S_DONE;
               end else begin
                  cidx_in = cidx_ff + 2'd1;
                  state_in = S_DIVI;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (hsum[32] != hsum[31]) rh_in = hsum[32] ? 32'h80000000 : 32'h7fffffff;
               else rh_in = hsum[31:0];
               rnx_in = ox_ff;
               rny_in = oy_ff;
               rnz_in = oz_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // heightmap memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[req_entry_index[ADDR_W-1:0]] <= req_entry_height;
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         origin_x_ff <= 32'd0;
         origin_z_ff <= 32'd0;
         base_height_ff <= 32'd0;
         inv_extent_ff <= 32'd16777216;
         sample_delta_ff <= 31'd65536;
         grid_cells_ff <= 9'd256;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_ORIGIN_X:     origin_x_ff <= csr_wdata;
               REG_ORIGIN_Z:     origin_z_ff <= csr_wdata;
               REG_BASE_HEIGHT:  base_height_ff <= csr_wdata;
               REG_INV_EXTENT:   inv_extent_ff <= csr_wdata;
               REG_SAMPLE_DELTA: sample_delta_ff <= csr_wdata[30:0];
               REG_GRID_CELLS:   grid_cells_ff <= csr_wdata[8:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      axis_ff <= axis_in; si_ff <= si_in; cidx_ff <= cidx_in; it_ff <= it_in;
      wx_ff <= wx_in; wz_ff <= wz_in; dxp_ff <= dxp_in; plo_ff <= plo_in;
      u24_ff <= u24_in; x0_ff <= x0_in; z0_ff <= z0_in; fx_ff <= fx_in; fz_ff <= fz_in;
      row0_ff <= row0_in; row1_ff <= row1_in;
      h00_ff <= h00_in; h10_ff <= h10_in; h01_ff <= h01_in; h11_ff <= h11_in;
      a_ff <= a_in; b_ff <= b_in; s0_ff <= s0_in; hx_ff <= hx_in; hz_ff <= hz_in;
      nx_ff <= nx_in; ny_ff <= ny_in; nz_ff <= nz_in; negx_ff <= negx_in; negz_ff <= negz_in;
      acc_ff <= acc_in; v_ff <= v_in; r_ff <= r_in; bit_ff <= bit_in;
      rem_ff <= rem_in; q_ff <= q_in; ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in;
      rh_ff <= rh_in; rnx_ff <= rnx_in; rny_ff <= rny_in; rnz_ff <= rnz_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_height   = rh_ff;
   assign rsp_normal_x = rnx_ff;
   assign rsp_normal_y = rny_ff;
   assign rsp_normal_z = rnz_ff;
endmodule
